>>> rtl/core/lwr_pkg.sv
// Shared types and constants for the LCD window RAM writer.
// No dependencies; every other file but lwr_stream_if imports this package.
package lwr_pkg;

	localparam int PANEL_SIZE_DEF = 240;
	localparam int MAX_ADDR_W     = 16;
	localparam int OP_FIFO_DEPTH  = 4;

	localparam logic [7:0] OPC_NONE  = 8'h00;
	localparam logic [7:0] OPC_CASET = 8'h2A;
	localparam logic [7:0] OPC_RASET = 8'h2B;
	localparam logic [7:0] OPC_RAMWR = 8'h2C;

	localparam logic [2:0] PARAM_LIMIT = 3'd4;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef struct packed {
		logic       mode;
		logic       chip_selected;
		logic       is_data;
		logic [7:0] byte_value;
		logic [7:0] read_col;
		logic [7:0] read_row;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pixel_color;
		logic [31:0] pixel_count;
	} out_item_t;

	// Memory operation passed from the front end to the back end.
	typedef struct packed {
		logic                  kind;
		logic                  in_panel;
		logic [MAX_ADDR_W-1:0] addr;
		logic [15:0]           pixel;
		logic [31:0]           count;
	} mem_op_t;

endpackage

>>> rtl/core/lwr_stream_if.sv
// Valid/ready stream interface used for the item channels.
// Payload type is a parameter; depends on nothing else.
interface lwr_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/lwr_op_fifo.sv
// Short queue of memory operations between front and back end.
// Depends on lwr_pkg for mem_op_t.
module lwr_op_fifo import lwr_pkg::*; #(
	parameter int DEPTH = OP_FIFO_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  mem_op_t push_op,
	output logic    full,
	input  logic    pop,
	output mem_op_t pop_op,
	output logic    empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mem_op_t          slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign pop_op = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end
endmodule

>>> rtl/core/lwr_front.sv
// Front end: accepts items, decodes commands and window parameters,
// steps the write cursor and issues memory operations. Depends on lwr_pkg.
module lwr_front import lwr_pkg::*; #(
	parameter int PANEL_SIZE = PANEL_SIZE_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid,
	input  in_item_t item,
	input  logic     accept,
	output logic     push,
	output mem_op_t  push_op
);
	localparam int DEPTH   = PANEL_SIZE * PANEL_SIZE;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int COORD_W = $clog2(PANEL_SIZE);

	logic [7:0]  opcode_q;
	logic [2:0]  param_idx_q;
	logic [15:0] col_start_q, col_end_q, row_start_q, row_end_q;
	logic [15:0] cursor_col_q, cursor_row_q;
	logic        high_pending_q;
	logic [7:0]  high_byte_q;
	logic [31:0] written_total_q;

	logic              byte_cmd, byte_data, pixel_done;
	logic              cur_in_panel, rd_in_panel;
	logic [ADDR_W-1:0] wr_addr, rd_addr;

	assign byte_cmd   = accept && !item.mode && item.chip_selected && !item.is_data;
	assign byte_data  = accept && !item.mode && item.chip_selected && item.is_data;
	assign pixel_done = byte_data && (opcode_q == OPC_RAMWR) && high_pending_q;

	always_comb begin
		cur_in_panel = (cursor_col_q < 16'(PANEL_SIZE)) && (cursor_row_q < 16'(PANEL_SIZE));
		rd_in_panel  = (9'(item.read_col) < 9'(PANEL_SIZE))
			&& (9'(item.read_row) < 9'(PANEL_SIZE));
		wr_addr = ADDR_W'(cursor_row_q[COORD_W-1:0]) * ADDR_W'(PANEL_SIZE)
			+ ADDR_W'(cursor_col_q[COORD_W-1:0]);
		rd_addr = ADDR_W'(item.read_row[COORD_W-1:0]) * ADDR_W'(PANEL_SIZE)
			+ ADDR_W'(item.read_col[COORD_W-1:0]);

		push_op.count = written_total_q;
		if (item.mode) begin
			push_op.kind     = KIND_READ;
			push_op.in_panel = rd_in_panel;
			push_op.addr     = MAX_ADDR_W'(rd_addr);
			push_op.pixel    = '0;
		end else begin
			push_op.kind     = KIND_WRITE;
			push_op.in_panel = cur_in_panel;
			push_op.addr     = MAX_ADDR_W'(wr_addr);
			push_op.pixel    = {high_byte_q, item.byte_value};
		end
		// drop pixels that fall outside the panel
		push = valid && accept && (item.mode || (pixel_done && cur_in_panel));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode_q        <= OPC_NONE;
			param_idx_q     <= '0;
			col_start_q     <= '0;
			col_end_q       <= '0;
			row_start_q     <= '0;
			row_end_q       <= '0;
			cursor_col_q    <= '0;
			cursor_row_q    <= '0;
			high_pending_q  <= 1'b0;
			high_byte_q     <= '0;
			written_total_q <= '0;
		end else if (byte_cmd) begin
			opcode_q    <= item.byte_value;
			param_idx_q <= '0;
			if (item.byte_value == OPC_RAMWR) begin
				cursor_col_q   <= col_start_q;
				cursor_row_q   <= row_start_q;
				high_pending_q <= 1'b0;
			end
		end else if (byte_data) begin
			unique case (opcode_q) inside
				OPC_CASET, OPC_RASET: begin
					case (param_idx_q)
						3'd0: begin
							if (opcode_q == OPC_CASET) col_start_q <= {item.byte_value, 8'h00};
							else                       row_start_q <= {item.byte_value, 8'h00};
						end
						3'd1: begin
							if (opcode_q == OPC_CASET) col_start_q[7:0] <= item.byte_value;
							else                       row_start_q[7:0] <= item.byte_value;
						end
						3'd2: begin
							if (opcode_q == OPC_CASET) col_end_q <= {item.byte_value, 8'h00};
							else                       row_end_q <= {item.byte_value, 8'h00};
						end
						3'd3: begin
							if (opcode_q == OPC_CASET) col_end_q[7:0] <= item.byte_value;
							else                       row_end_q[7:0] <= item.byte_value;
						end
						default: ;
					endcase
					if (param_idx_q < PARAM_LIMIT)
						param_idx_q <= param_idx_q + 1'b1;
				end
				OPC_RAMWR: begin
					if (!high_pending_q) begin
						high_byte_q    <= item.byte_value;
						high_pending_q <= 1'b1;
					end else begin
						high_pending_q  <= 1'b0;
						written_total_q <= written_total_q + 32'd1;
						// advance the cursor through the window
						if (cursor_col_q >= col_end_q) begin
							cursor_col_q <= col_start_q;
							cursor_row_q <= (cursor_row_q >= row_end_q) ? row_start_q
								: cursor_row_q + 16'd1;
						end else begin
							cursor_col_q <= cursor_col_q + 16'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

>>> rtl/core/lwr_back.sv
// Back end: clears the frame memory after reset, then executes queued
// writes and reads and holds read results for the output. Depends on lwr_pkg.
module lwr_back import lwr_pkg::*; #(
	parameter int PANEL_SIZE = PANEL_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_empty,
	input  mem_op_t   op,
	output logic      pop,
	output logic      clear_done,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	localparam int DEPTH  = PANEL_SIZE * PANEL_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [15:0]       mem [DEPTH];
	logic [15:0]       rd_data_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clear_done_q;

	logic        s1_valid_q, s1_in_panel_s1;
	logic [31:0] s1_count_s1;
	logic        out_valid_q;
	out_item_t   out_data_q;

	logic              s1_adv, s1_free, rd_en, wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [15:0]       wr_data;

	assign clear_done = clear_done_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;

	always_comb begin
		s1_adv  = s1_valid_q && (!out_valid_q || out_ready);
		s1_free = !s1_valid_q || s1_adv;
		pop     = clear_done_q && !op_empty && ((op.kind == KIND_WRITE) || s1_free);
		rd_en   = pop && (op.kind == KIND_READ);
		wr_en   = !clear_done_q || (pop && (op.kind == KIND_WRITE));
		wr_addr = clear_done_q ? op.addr[ADDR_W-1:0] : clr_addr_q;
		wr_data = clear_done_q ? op.pixel : 16'h0000;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[op.addr[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			s1_in_panel_s1 <= op.in_panel;
			s1_count_s1    <= op.count;
		end
		if (s1_adv)
			out_data_q <= '{pixel_color: s1_in_panel_s1 ? rd_data_q : 16'h0000,
				pixel_count: s1_count_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			clear_done_q <= 1'b0;
			s1_valid_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (!clear_done_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == ADDR_W'(DEPTH - 1))
					clear_done_q <= 1'b1;
			end
			if (rd_en)
				s1_valid_q <= 1'b1;
			else if (s1_adv)
				s1_valid_q <= 1'b0;
			if (s1_adv)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end
endmodule

>>> rtl/core/lcd_window_ram_writer.sv
// LCD window RAM writer: byte and read-request items in, read results out.
// Depends on lwr_pkg, lwr_stream_if, lwr_front, lwr_op_fifo, lwr_back.
// Throughput: one item per cycle while req.ready is high; reads and byte
// transfers may be mixed freely. Read path: op FIFO, memory read register,
// output register. Reset: control clears at once; then a clearing pass
// zeroes the frame memory, one entry a cycle, with req.ready held low.
module lcd_window_ram_writer import lwr_pkg::*; #(
	parameter int PANEL_SIZE = PANEL_SIZE_DEF
) (
	input logic          clk,
	input logic          arst_n,
	lwr_stream_if.sink   req,
	lwr_stream_if.source rsp
);
	logic    fifo_full, fifo_empty, push, pop, clear_done, accept;
	mem_op_t push_op, pop_op;

	assign req.ready = clear_done && !fifo_full;
	assign accept    = req.valid && req.ready;

	lwr_front #(.PANEL_SIZE(PANEL_SIZE)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (req.valid),
		.item    (req.data),
		.accept  (accept),
		.push    (push),
		.push_op (push_op)
	);

	lwr_op_fifo #(.DEPTH(OP_FIFO_DEPTH)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (fifo_full),
		.pop     (pop),
		.pop_op  (pop_op),
		.empty   (fifo_empty)
	);

	lwr_back #(.PANEL_SIZE(PANEL_SIZE)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_empty   (fifo_empty),
		.op         (pop_op),
		.pop        (pop),
		.clear_done (clear_done),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_data   (rsp.data)
	);
endmodule

>>> sim/lwr_readback_checker.sv
`timescale 1ns / 1ps
// Read-back checker for the LCD window RAM writer: models the command decoder,
// the window cursor and the frame memory, and checks every read result.
// Depends on lwr_pkg for item types, opcodes and the panel size.
module lwr_readback_checker import lwr_pkg::*; #(
	parameter int PANEL = PANEL_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  in_item_t  req_data,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  out_item_t rsp_data,
	output int        fails,
	output int        pending
);

	logic [7:0]  opcode;
	logic [2:0]  param_cnt;
	logic [15:0] col_lo, col_hi, row_lo, row_hi;
	logic [15:0] cur_col, cur_row;
	logic        hi_pending;
	logic [7:0]  hi_byte;
	logic [15:0] gram_model [PANEL*PANEL];
	logic [31:0] pixel_total;
	out_item_t   readback_q [$];
	out_item_t   want;

	// Window registers load big-endian: start high, start low, end high, end low.
	task automatic load_window(inout logic [15:0] lo, inout logic [15:0] hi,
			input logic [7:0] b);
		case (param_cnt)
			3'd0: lo = {b, 8'h00};
			3'd1: lo = lo | {8'h00, b};
			3'd2: hi = {b, 8'h00};
			3'd3: hi = hi | {8'h00, b};
			default: ;
		endcase
		if (param_cnt < PARAM_LIMIT)
			param_cnt = param_cnt + 3'd1;
	endtask

	task automatic commit_pixel(input logic [15:0] px);
		if (cur_col < PANEL && cur_row < PANEL)
			gram_model[int'(cur_row) * PANEL + int'(cur_col)] = px;
		pixel_total = pixel_total + 32'd1;
		// Advance through the window, wrapping rows back to the window start.
		if (cur_col >= col_hi) begin
			cur_col = col_lo;
			cur_row = (cur_row >= row_hi) ? row_lo : cur_row + 16'd1;
		end else begin
			cur_col = cur_col + 16'd1;
		end
	endtask

	task automatic absorb_byte(input logic is_data, input logic [7:0] b);
		if (!is_data) begin
			opcode = b;
			param_cnt = '0;
			if (b == OPC_RAMWR) begin
				cur_col = col_lo;
				cur_row = row_lo;
				hi_pending = 1'b0;
			end
		end else begin
			case (opcode)
				OPC_CASET: load_window(col_lo, col_hi, b);
				OPC_RASET: load_window(row_lo, row_hi, b);
				OPC_RAMWR: begin
					if (!hi_pending) begin
						hi_byte = b;
						hi_pending = 1'b1;
					end else begin
						hi_pending = 1'b0;
						commit_pixel({hi_byte, b});
					end
				end
				default: ;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode = OPC_NONE;
			param_cnt = '0;
			col_lo = '0;
			col_hi = '0;
			row_lo = '0;
			row_hi = '0;
			cur_col = '0;
			cur_row = '0;
			hi_pending = 1'b0;
			hi_byte = '0;
			pixel_total = '0;
			for (int i = 0; i < PANEL * PANEL; i++)
				gram_model[i] = '0;
			readback_q.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (req_valid && req_ready) begin
				if (req_data.mode == KIND_READ) begin
					want.pixel_color = '0;
					if (req_data.read_col < PANEL && req_data.read_row < PANEL)
						want.pixel_color = gram_model[int'(req_data.read_row) * PANEL
							+ int'(req_data.read_col)];
					want.pixel_count = pixel_total;
					readback_q.push_back(want);
				end else if (req_data.chip_selected) begin
					absorb_byte(req_data.is_data, req_data.byte_value);
				end
			end
			if (rsp_valid && rsp_ready) begin
				if (readback_q.size() == 0) begin
					$display("%0t: unexpected result, got color %h count %h", $time,
						rsp_data.pixel_color, rsp_data.pixel_count);
					fails++;
				end else begin
					want = readback_q.pop_front();
					if (rsp_data.pixel_color !== want.pixel_color) begin
						$display("%0t: pixel_color mismatch, expected %h, got %h", $time,
							want.pixel_color, rsp_data.pixel_color);
						fails++;
					end
					if (rsp_data.pixel_count !== want.pixel_count) begin
						$display("%0t: pixel_count mismatch, expected %h, got %h", $time,
							want.pixel_count, rsp_data.pixel_count);
						fails++;
					end
				end
			end
			pending = readback_q.size();
		end
	end

endmodule

>>> sim/tb_lcd_window_ram_writer.sv
`timescale 1ns / 1ps
// Testbench top for the LCD window RAM writer: drives command, window and pixel
// bytes plus read-backs, stalls the result side; lwr_readback_checker judges.
module tb_lcd_window_ram_writer;
	import lwr_pkg::*;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   burst_left;
	int   work_items;
	bit   drained_mid;

	lwr_stream_if #(.T(in_item_t))  req_if ();
	lwr_stream_if #(.T(out_item_t)) rsp_if ();

	lcd_window_ram_writer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	lwr_readback_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_if.valid),
		.req_ready (req_if.ready),
		.req_data  (req_if.data),
		.rsp_valid (rsp_if.valid),
		.rsp_ready (rsp_if.ready),
		.rsp_data  (rsp_if.data),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Covers the clearing pass plus a slow run several times over.
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Result side: switch between randomly chosen stall styles, each held for a phase of random length.
	initial begin : rsp_stall
		int          phase;
		int          stall_kind;
		logic [15:0] pat;
		rsp_if.ready = 1'b0;
		phase = 0;
		stall_kind = 0;
		pat = '1;
		forever begin
			@(negedge clk);
			if (phase == 0) begin
				phase = $urandom_range(16, 128);
				stall_kind = $urandom_range(0, 3);
				pat = 16'($urandom) | 16'h0001;
			end
			phase--;
			case (stall_kind)
				0: rsp_if.ready <= 1'b1;
				1: rsp_if.ready <= pat[4'(phase)];
				2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
				default: rsp_if.ready <= 1'($urandom);
			endcase
		end
	end

	function automatic in_item_t bus_item(logic cs, logic dc, logic [7:0] b);
		in_item_t it;
		it.mode = KIND_WRITE;
		it.chip_selected = cs;
		it.is_data = dc;
		it.byte_value = b;
		it.read_col = 8'($urandom);
		it.read_row = 8'($urandom);
		return it;
	endfunction

	function automatic in_item_t read_item(logic [7:0] col, logic [7:0] row);
		in_item_t it;
		it = in_item_t'($urandom);
		it.mode = KIND_READ;
		it.read_col = col;
		it.read_row = row;
		return it;
	endfunction

	// Send in bursts; the gap before a burst holds valid low.
	task automatic push_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.data <= it;
		do @(posedge clk); while (!req_if.ready);
		@(negedge clk);
		if (it.mode == KIND_READ || it.chip_selected)
			work_items++;
	endtask

	task automatic send_cmd(input logic [7:0] b);
		push_item(bus_item(1'b1, 1'b0, b));
	endtask

	task automatic send_data(input logic [7:0] b);
		push_item(bus_item(1'b1, 1'b1, b));
	endtask

	task automatic send_pixel(input logic [15:0] px);
		send_data(px[15:8]);
		send_data(px[7:0]);
	endtask

	task automatic send_window(input logic [7:0] op, input logic [15:0] lo,
			input logic [15:0] hi);
		send_cmd(op);
		send_data(lo[15:8]);
		send_data(lo[7:0]);
		send_data(hi[15:8]);
		send_data(hi[7:0]);
		// Extra parameter bytes past the fourth are dropped.
		if ($urandom_range(0, 5) == 0)
			send_data(8'($urandom));
	endtask

	// Hold off until every read result has come back.
	task automatic drain;
		req_if.valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending != 0);
	endtask

	function automatic logic [15:0] pick_start();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'($urandom_range(228, 255));
			default: return 16'($urandom_range(0, 239));
		endcase
	endfunction

	function automatic logic [15:0] pick_end(logic [15:0] lo);
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom_range(0, int'(lo)));
		return lo + 16'($urandom_range(0, 7));
	endfunction

	task automatic window_write;
		logic [15:0] c0, c1, r0, r1;
		int          npix;
		c0 = pick_start();
		c1 = pick_end(c0);
		r0 = pick_start();
		r1 = pick_end(r0);
		if ($urandom_range(0, 4) != 0)
			send_window(OPC_CASET, c0, c1);
		if ($urandom_range(0, 4) != 0)
			send_window(OPC_RASET, r0, r1);
		send_cmd(OPC_RAMWR);
		npix = $urandom_range(1, 24);
		for (int i = 0; i < npix; i++) begin
			send_pixel(16'($urandom));
			case ($urandom_range(0, 11))
				0: push_item(read_item(8'(c0 + 16'($urandom_range(0, 7))),
					8'(r0 + 16'($urandom_range(0, 3)))));
				1: push_item(bus_item(1'b0, 1'($urandom), 8'($urandom)));
				default: ;
			endcase
		end
		if ($urandom_range(0, 5) == 0)
			send_data(8'($urandom));
		repeat ($urandom_range(1, 4))
			push_item(read_item(8'(c0 + 16'($urandom_range(0, 7))),
				8'(r0 + 16'($urandom_range(0, 3)))));
	endtask

	initial begin
		in_item_t it;
		logic [7:0] op;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		burst_left = 0;
		work_items = 0;
		drained_mid = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed: read before any write, deselected command, window across
		// the panel edge, extra parameter byte, cursor stepping out of the panel.
		push_item(read_item(8'hFF, 8'hFF));
		push_item(bus_item(1'b0, 1'b0, OPC_CASET));
		send_window(OPC_CASET, 16'd238, 16'd241);
		send_data(8'h7F);
		send_window(OPC_RASET, 16'd239, 16'd240);
		send_cmd(OPC_RAMWR);
		send_pixel(16'hFFFF);
		send_pixel(16'h0001);
		send_pixel(16'h8000);
		send_pixel(16'h1234);
		send_pixel(16'hABCD);
		push_item(read_item(8'd238, 8'd239));
		push_item(read_item(8'd239, 8'd239));
		drain();

		while (work_items < 1975) begin
			if (!drained_mid && work_items > 1000) begin
				drain();
				drained_mid = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: window_write();
				6, 7: repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 3) == 0)
						push_item(read_item(8'($urandom), 8'($urandom)));
					else
						push_item(read_item(8'($urandom_range(0, 239)),
							8'($urandom_range(0, 239))));
				end
				8: repeat ($urandom_range(1, 4)) begin
					it = in_item_t'($urandom);
					push_item(it);
				end
				default: begin
					// Data under an opcode the block does not decode is dropped.
					do op = 8'($urandom);
					while (op == OPC_CASET || op == OPC_RASET || op == OPC_RAMWR);
					send_cmd(op);
					repeat ($urandom_range(1, 4))
						send_data(8'($urandom));
				end
			endcase
		end

		req_if.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> lcd_window_ram_writer.f
rtl/core/lwr_pkg.sv
rtl/core/lwr_stream_if.sv
rtl/core/lwr_op_fifo.sv
rtl/core/lwr_front.sv
rtl/core/lwr_back.sv
rtl/core/lcd_window_ram_writer.sv
sim/lwr_readback_checker.sv
sim/tb_lcd_window_ram_writer.sv
